// ----- sv/assert_macros.svh -----
// Assertion macros shared by the ready queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/mpq_pkg.sv -----
// Package with the sizes, codes and state type of the ready queue.
`default_nettype none

package mpq_pkg;

    localparam int MAX_PROC    = 32;                 // ids 0 .. MAX_PROC-1
    localparam int LEVELS      = 4;                  // priority levels, 0 highest
    localparam int ID_W        = 5;                  // id field width
    localparam int LVL_W       = 4;                  // level field width
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 3;
    localparam int CNT_W       = 6;
    localparam int PID_W       = $clog2(MAX_PROC);   // id index bits
    localparam int LIDX_W      = $clog2(LEVELS);     // level index bits
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_POP     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_REPRIO  = 3'd3,
        CMD_FIND    = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_QUEUED = 3'd1,
        ST_BAD_LEVEL  = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_DUPLICATE  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_UNL,
        S_WRD,
        S_WCHK,
        S_FIN,
        S_LINK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- sv/mpq_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module mpq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 5,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/multilevel_priority_ready_queue.sv -----
// Top level of the multilevel priority ready queue.
//
//  channel   direction  signals                 fields (lowest bit up)
//  s_axis    in         tvalid tready tdata     cmd[2:0] proc_id[7:3] level[11:8]
//  m_axis    out        tvalid tready tdata     status[2:0] out_id[7:3]
//                                               out_level[11:8] total_queued[17:12]
//
// One command is in work at a time: rejected or unknown ones go to S_DONE, insert
// via S_LINK, find via S_RD and S_UNL, pop or remove via S_RD, S_UNL, S_FIN; a
// removal below a level head walks S_WRD/S_WCHK per link, reprioritize adds S_LINK.
// Reset clears heads, tails, queued bits and the count; the RAMs need no clearing.
// A stalled output holds its result; the next command is taken meanwhile and
// waits in its final state until the output register is free.
`default_nettype none

module multilevel_priority_ready_queue (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // cmd[2:0], proc_id[7:3], level[11:8], zero fill
    input  wire logic [mpq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // status[2:0], out_id[7:3], out_level[11:8], total_queued[17:12], zero fill
    output logic      [mpq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import mpq_pkg::*;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [ID_W-1:0]       r_id, n_id;
    logic [LVL_W-1:0]      r_lv, n_lv;
    logic [LIDX_W-1:0]     r_ulv, n_ulv;
    logic [PID_W-1:0]      r_prev, n_prev;
    logic [PID_W-1:0]      r_nid, n_nid;
    t_status               r_status, n_status;
    logic [ID_W-1:0]       r_oid, n_oid;
    logic [LVL_W-1:0]      r_olv, n_olv;

    logic [LEVELS-1:0]     r_nonempty, n_nonempty;
    logic [PID_W-1:0]      r_head [LEVELS];
    logic [PID_W-1:0]      n_head [LEVELS];
    logic [PID_W-1:0]      r_tail [LEVELS];
    logic [PID_W-1:0]      n_tail [LEVELS];
    logic [MAX_PROC-1:0]   r_queued, n_queued;
    logic [CNT_W-1:0]      r_count, n_count;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  link_we;
    logic [PID_W-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
    logic                  lvl_we;
    logic [LIDX_W-1:0]     lvl_wdata, lvl_rdata;

    t_cmd                  in_cmd;
    logic [ID_W-1:0]       in_id;
    logic [LVL_W-1:0]      in_lv;
    logic                  in_id_ok, in_lv_ok, in_queued;
    logic                  pop_found;
    logic [LIDX_W-1:0]     pop_lv;
    logic [LIDX_W-1:0]     cur_lv;
    logic [PID_W-1:0]      id_idx;

    assign in_cmd    = t_cmd'(i_s_axis_tdata[2:0]);
    assign in_id     = i_s_axis_tdata[7:3];
    assign in_lv     = i_s_axis_tdata[11:8];
    assign in_id_ok  = 32'(in_id) < 32'(MAX_PROC);
    assign in_lv_ok  = 32'(in_lv) < 32'(LEVELS);
    assign in_queued = in_id_ok && r_queued[in_id[PID_W-1:0]];
    assign id_idx    = r_id[PID_W-1:0];

    // Highest non-empty level for pop.
    always_comb begin
        pop_found = 1'b0;
        pop_lv    = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_nonempty[l]) begin
                pop_found = 1'b1;
                pop_lv    = LIDX_W'(l);
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The walk reads the predecessor's link; every other read is at the command's id.
    assign link_raddr = (r_state == S_WRD) ? r_prev : id_idx;

    // Level of the entry being unlinked: pop knows it, the others read it.
    assign cur_lv = (r_cmd == CMD_POP) ? r_ulv : lvl_rdata;

    mpq_ram #(
        .DEPTH (MAX_PROC),
        .WIDTH (PID_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    mpq_ram #(
        .DEPTH (MAX_PROC),
        .WIDTH (LIDX_W)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (id_idx),
        .i_wdata (lvl_wdata),
        .i_raddr (id_idx),
        .o_rdata (lvl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nonempty  <= '0;
            r_queued    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_queued    <= n_queued;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_lv       <= n_lv;
        r_ulv      <= n_ulv;
        r_prev     <= n_prev;
        r_nid      <= n_nid;
        r_status   <= n_status;
        r_oid      <= n_oid;
        r_olv      <= n_olv;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_lv        = r_lv;
        n_ulv       = r_ulv;
        n_prev      = r_prev;
        n_nid       = r_nid;
        n_status    = r_status;
        n_oid       = r_oid;
        n_olv       = r_olv;
        n_nonempty  = r_nonempty;
        n_head      = r_head;
        n_tail      = r_tail;
        n_queued    = r_queued;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        link_we     = 1'b0;
        link_waddr  = r_prev;
        link_wdata  = r_nid;
        lvl_we      = 1'b0;
        lvl_wdata   = r_lv[LIDX_W-1:0];

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd    = in_cmd;
                    n_id     = in_id;
                    n_lv     = in_lv;
                    n_status = ST_OK;
                    n_oid    = '0;
                    n_olv    = '0;
                    n_state  = S_DONE;
                    unique case (in_cmd) inside
                        CMD_INSERT: begin
                            if (!in_id_ok) begin
                                n_status = ST_NOT_QUEUED;
                            end else if (!in_lv_ok) begin
                                n_status = ST_BAD_LEVEL;
                            end else if (in_queued) begin
                                n_status = ST_DUPLICATE;
                            end else begin
                                n_state = S_LINK;
                            end
                        end
                        CMD_POP: begin
                            if (!pop_found) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_id    = ID_W'(r_head[pop_lv]);
                                n_ulv   = pop_lv;
                                n_oid   = ID_W'(r_head[pop_lv]);
                                n_olv   = LVL_W'(pop_lv);
                                n_state = S_RD;
                            end
                        end
                        CMD_REMOVE, CMD_REPRIO, CMD_FIND: begin
                            if (!in_queued) begin
                                n_status = ST_NOT_QUEUED;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_RD: begin
                // Level and link of the id are read here and arrive next cycle.
                n_state = S_UNL;
            end

            S_UNL: begin
                n_ulv = cur_lv;
                n_nid = link_rdata;
                if (r_cmd == CMD_FIND) begin
                    n_oid   = r_id;
                    n_olv   = LVL_W'(lvl_rdata);
                    n_state = S_DONE;
                end else if (r_head[cur_lv] == id_idx) begin
                    if (r_tail[cur_lv] == id_idx) begin
                        n_nonempty[cur_lv] = 1'b0;
                    end else begin
                        n_head[cur_lv] = link_rdata;
                    end
                    n_state = S_FIN;
                end else begin
                    n_prev  = r_head[cur_lv];
                    n_state = S_WRD;
                end
            end

            S_WRD: begin
                if (r_prev == r_tail[r_ulv]) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_WCHK;
                end
            end

            S_WCHK: begin
                if (link_rdata == id_idx) begin
                    // Bridge the predecessor over the removed entry.
                    link_we    = 1'b1;
                    link_waddr = r_prev;
                    link_wdata = r_nid;
                    if (r_tail[r_ulv] == id_idx) begin
                        n_tail[r_ulv] = r_prev;
                    end
                    n_state = S_FIN;
                end else begin
                    n_prev  = link_rdata;
                    n_state = S_WRD;
                end
            end

            S_FIN: begin
                n_queued[id_idx] = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
                n_state = S_DONE;
                if (r_cmd == CMD_REPRIO) begin
                    if (32'(r_lv) < 32'(LEVELS)) begin
                        n_state = S_LINK;
                    end else begin
                        n_status = ST_BAD_LEVEL;
                    end
                end
            end

            S_LINK: begin
                // The new tail's own link is written once it gains a successor.
                if (r_nonempty[r_lv[LIDX_W-1:0]]) begin
                    link_we    = 1'b1;
                    link_waddr = r_tail[r_lv[LIDX_W-1:0]];
                    link_wdata = id_idx;
                end else begin
                    n_head[r_lv[LIDX_W-1:0]]     = id_idx;
                    n_nonempty[r_lv[LIDX_W-1:0]] = 1'b1;
                end
                n_tail[r_lv[LIDX_W-1:0]] = id_idx;
                n_queued[id_idx]         = 1'b1;
                lvl_we                   = 1'b1;
                lvl_wdata                = r_lv[LIDX_W-1:0];
                n_count                  = r_count + CNT_W'(1);
                n_state                  = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_count, r_olv, r_oid, r_status});
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `include "assert_macros.svh"

    `MPQ_ASSERT(a_count_matches, i_clk, i_rst_n, 32'(r_count) == $countones(r_queued), "bad count")
    `MPQ_ASSERT(a_link_unqueued, i_clk, i_rst_n, (r_state == S_LINK) |-> !r_queued[id_idx], "relink")
    `MPQ_ASSERT(a_empty_levels, i_clk, i_rst_n, (r_count == '0) |-> (r_nonempty == '0), "level set")
    `MPQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid, "reset")

endmodule

`default_nettype wire
